/* sv/lzt_pkg.sv */
// Shared types and constants for the LZ77 type 0x10 decompressor.
// Used by lzt_hist_mem and lz77_type10_decompressor; depends on nothing.
package lzt_pkg;

    localparam int HIST_DEPTH = 4096;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    localparam logic [7:0] MAGIC_BYTE       = 8'h10;
    localparam logic [4:0] MIN_MATCH        = 5'd3;
    localparam logic [3:0] TOKENS_PER_GROUP = 4'd8;
    localparam logic [1:0] HDR_LAST_INDEX   = 2'd2;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_HEADER,
        PH_FLAG,
        PH_TOKEN,
        PH_REFLO,
        PH_DONE,
        PH_ERROR
    } t_phase;

    typedef enum logic {
        E_IDLE,
        E_COPY
    } t_eng;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_MAGIC,
        ST_DIST_LEN,
        ST_DIST_PROD
    } t_status;

    typedef struct packed {
        logic               en;
        logic [HIST_AW-1:0] addr;
        logic [7:0]         data;
    } t_hist_wr;

    typedef struct packed {
        logic               en;
        logic [HIST_AW-1:0] addr;
    } t_hist_rd;

endpackage

/* sv/lzt_hist_mem.sv */
// History window memory: one write port, one registered read port.
// Depends on lzt_pkg; a read of the entry written in the same cycle returns the new byte.
module lzt_hist_mem import lzt_pkg::*; (
    input  logic       i_clk,
    input  t_hist_wr   i_wr,
    input  t_hist_rd   i_rd,
    output logic [7:0] o_rd_data
);

    logic [7:0] r_mem [HIST_DEPTH];
    logic [7:0] r_rd_data;
    logic [7:0] r_fwd_data;
    logic       r_fwd_sel;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data  <= r_mem[i_rd.addr];
            r_fwd_sel  <= i_wr.en && (i_wr.addr == i_rd.addr);
            r_fwd_data <= i_wr.data;
        end
    end

    // The array read returns the old byte on a same-address collision.
    assign o_rd_data = r_fwd_sel ? r_fwd_data : r_rd_data;

endmodule

/* sv/lz77_type10_decompressor.sv */
// Top level of the LZ77 type 0x10 decompressor: stream parser and copy engine.
// Depends on lzt_pkg and lzt_hist_mem.
//
// Usage. Compressed bytes enter on the input channel (i_valid, o_stall,
// i_in_byte, i_start_of_stream); an item is taken at a rising edge with
// i_valid high and o_stall low. Every input item causes one or more result
// items on the output channel (o_valid, i_stall and the payload ports); the
// last result of each input item carries o_last_of_run. An input item that
// produces no byte gives a single result with o_byte_valid low.
// Timing. Header, flag and literal results are registered, and each sits in
// the output register in the cycle after acceptance. The second byte of a
// reference starts a copy: the first history read is issued in the accepting
// cycle, and then one byte is emitted per cycle while i_stall does not hold
// the output register. The single-port read of the 4096-byte history memory
// sets that one-byte-per-cycle copy rate.
// Reset. i_rst_n is synchronous and active low; it returns the parser to the
// magic-byte wait and empties the output register. The history memory is not
// cleared; the distance checks keep unwritten entries from being read.
// Backpressure. While i_stall holds a result in the output register, the
// copy engine pauses and no new input item is taken.
module lz77_type10_decompressor import lzt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_start_of_stream,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_last_of_run,
    output logic       o_stream_done,
    output logic [1:0] o_status
);

    // Parser and engine state.
    t_phase       r_phase, n_phase;
    t_eng         r_eng, n_eng;
    t_status      r_err, n_err;
    logic [23:0]  r_prod, n_prod;
    logic [23:0]  r_target, n_target;
    logic [1:0]   r_hidx, n_hidx;
    logic [7:0]   r_flags, n_flags;
    logic [3:0]   r_tidx, n_tidx;
    logic [7:0]   r_pend, n_pend;
    logic [HIST_AW-1:0] r_src, n_src;
    logic [4:0]   r_rem, n_rem;

    // Output register.
    logic         r_o_valid, n_o_valid;
    logic [7:0]   r_o_byte, n_o_byte;
    logic         r_o_bvalid, n_o_bvalid;
    logic         r_o_last, n_o_last;
    logic         r_o_done, n_o_done;
    t_status      r_o_status, n_o_status;

    // History memory ports.
    t_hist_wr     hist_wr;
    t_hist_rd     hist_rd;
    logic [7:0]   hist_q;

    logic         out_free;
    logic         in_fire;
    logic         copy_fire;
    logic         copy_last;
    t_phase       cur_phase;
    logic [23:0]  prod_inc;
    logic         prod_reach;
    logic [3:0]   tidx_inc;
    t_phase       tok_more_phase;
    logic [23:0]  hdr_target;
    logic [12:0]  ref_dist;
    logic [HIST_AW-1:0] ref_src;

    lzt_hist_mem u_hist (
        .i_clk     (i_clk),
        .i_wr      (hist_wr),
        .i_rd      (hist_rd),
        .o_rd_data (hist_q)
    );

    // The output slot can be loaded when it is empty or being drained now.
    assign out_free  = !r_o_valid || !i_stall;
    assign o_stall   = (r_eng != E_IDLE) || !out_free;
    assign in_fire   = i_valid && !o_stall;
    assign copy_fire = (r_eng == E_COPY) && out_free;

    // The produced count never passes the declared length, so reaching it is
    // the same test as the count after this byte being at least the length.
    assign prod_inc   = r_prod + 24'd1;
    assign prod_reach = (prod_inc >= r_target);
    assign copy_last  = (r_rem == 5'd1) || prod_reach;

    // What the parser does after a token completes without ending the stream.
    assign tidx_inc       = r_tidx + 4'd1;
    assign tok_more_phase = (tidx_inc >= TOKENS_PER_GROUP) ? PH_FLAG : PH_TOKEN;

    assign ref_dist = {1'b0, r_pend[3:0], i_in_byte} + 13'd1;
    assign ref_src  = r_prod[HIST_AW-1:0] - ref_dist[HIST_AW-1:0];

    always_comb begin
        hdr_target = r_target;
        case (r_hidx)
            2'd0:    hdr_target[7:0]   = r_target[7:0]   | i_in_byte;
            2'd1:    hdr_target[15:8]  = r_target[15:8]  | i_in_byte;
            2'd2:    hdr_target[23:16] = r_target[23:16] | i_in_byte;
            default: hdr_target = r_target;
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_eng      = r_eng;
        n_err      = r_err;
        n_prod     = r_prod;
        n_target   = r_target;
        n_hidx     = r_hidx;
        n_flags    = r_flags;
        n_tidx     = r_tidx;
        n_pend     = r_pend;
        n_src      = r_src;
        n_rem      = r_rem;
        n_o_valid  = r_o_valid && i_stall;
        n_o_byte   = r_o_byte;
        n_o_bvalid = r_o_bvalid;
        n_o_last   = r_o_last;
        n_o_done   = r_o_done;
        n_o_status = r_o_status;
        hist_wr    = '0;
        hist_rd    = '0;
        cur_phase  = i_start_of_stream ? PH_MAGIC : r_phase;

        if (in_fire) begin
            // Default result: a single item that carries no byte.
            n_o_valid  = 1'b1;
            n_o_byte   = 8'd0;
            n_o_bvalid = 1'b0;
            n_o_last   = 1'b1;

            case (cur_phase)
                PH_MAGIC: begin
                    n_prod   = '0;
                    n_target = '0;
                    n_hidx   = '0;
                    n_flags  = '0;
                    n_tidx   = '0;
                    n_pend   = '0;
                    n_err    = ST_OK;
                    if (i_in_byte != MAGIC_BYTE) begin
                        n_err   = ST_BAD_MAGIC;
                        n_phase = PH_ERROR;
                    end else begin
                        n_phase = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    n_target = hdr_target;
                    n_hidx   = r_hidx + 2'd1;
                    if (r_hidx == HDR_LAST_INDEX) begin
                        n_phase = (hdr_target == '0) ? PH_DONE : PH_FLAG;
                    end
                end
                PH_FLAG: begin
                    n_flags = i_in_byte;
                    n_tidx  = '0;
                    n_phase = PH_TOKEN;
                end
                PH_TOKEN: begin
                    if (r_flags[7]) begin
                        n_pend  = i_in_byte;
                        n_phase = PH_REFLO;
                    end else begin
                        hist_wr.en   = 1'b1;
                        hist_wr.addr = r_prod[HIST_AW-1:0];
                        hist_wr.data = i_in_byte;
                        n_prod       = prod_inc;
                        n_o_byte     = i_in_byte;
                        n_o_bvalid   = 1'b1;
                        n_flags      = {r_flags[6:0], 1'b0};
                        n_tidx       = tidx_inc;
                        n_phase      = prod_reach ? PH_DONE : tok_more_phase;
                    end
                end
                PH_REFLO: begin
                    if ({11'd0, ref_dist} > r_target) begin
                        n_err   = ST_DIST_LEN;
                        n_phase = PH_ERROR;
                    end else if ({11'd0, ref_dist} > r_prod) begin
                        n_err   = ST_DIST_PROD;
                        n_phase = PH_ERROR;
                    end else begin
                        // A valid reference always yields at least one byte,
                        // so the result comes from the copy engine instead.
                        n_o_valid    = 1'b0;
                        n_eng        = E_COPY;
                        hist_rd.en   = 1'b1;
                        hist_rd.addr = ref_src;
                        n_src        = ref_src + 1'b1;
                        n_rem        = MIN_MATCH + {1'b0, r_pend[7:4]};
                    end
                end
                default: begin
                end
            endcase

            n_o_done   = n_o_bvalid ? prod_reach : (n_phase == PH_DONE);
            n_o_status = n_err;
        end else if (copy_fire) begin
            // Emit one copied byte and fetch the next one, if any.
            hist_wr.en   = 1'b1;
            hist_wr.addr = r_prod[HIST_AW-1:0];
            hist_wr.data = hist_q;
            n_prod       = prod_inc;
            n_o_valid    = 1'b1;
            n_o_byte     = hist_q;
            n_o_bvalid   = 1'b1;
            n_o_last     = copy_last;
            n_o_done     = prod_reach;
            n_o_status   = r_err;
            if (copy_last) begin
                n_eng   = E_IDLE;
                n_flags = {r_flags[6:0], 1'b0};
                n_tidx  = tidx_inc;
                n_phase = prod_reach ? PH_DONE : tok_more_phase;
            end else begin
                hist_rd.en   = 1'b1;
                hist_rd.addr = r_src;
                n_src        = r_src + 1'b1;
                n_rem        = r_rem - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_MAGIC;
            r_eng     <= E_IDLE;
            r_err     <= ST_OK;
            r_prod    <= '0;
            r_target  <= '0;
            r_hidx    <= '0;
            r_flags   <= '0;
            r_tidx    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_eng     <= n_eng;
            r_err     <= n_err;
            r_prod    <= n_prod;
            r_target  <= n_target;
            r_hidx    <= n_hidx;
            r_flags   <= n_flags;
            r_tidx    <= n_tidx;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend     <= n_pend;
        r_src      <= n_src;
        r_rem      <= n_rem;
        r_o_byte   <= n_o_byte;
        r_o_bvalid <= n_o_bvalid;
        r_o_last   <= n_o_last;
        r_o_done   <= n_o_done;
        r_o_status <= n_o_status;
    end

    assign o_valid       = r_o_valid;
    assign o_out_byte    = r_o_byte;
    assign o_byte_valid  = r_o_bvalid;
    assign o_last_of_run = r_o_last;
    assign o_stream_done = r_o_done;
    assign o_status      = r_o_status;

`ifndef SYNTHESIS
    a_copy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_eng == E_COPY) |-> o_stall)
        else $error("input accepted while a copy is running");

    a_copy_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_eng == E_COPY) |-> (r_rem != 5'd0))
        else $error("copy engine running with no bytes left");

    a_prod_within_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_MAGIC) |-> (r_prod <= r_target))
        else $error("produced count passed the declared length");

    a_copy_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (copy_fire && copy_last) |=> (r_eng == E_IDLE) && r_o_last)
        else $error("copy did not end on its last byte");
`endif

endmodule

/* tb/lz77_type10_decompressor_tb.sv */
// Self-checking testbench for lz77_type10_decompressor: directed streams, then random streams.
// A behavioral decoder predicts results of untyped items. Depends on lzt_pkg and the decompressor RTL.
module lz77_type10_decompressor_tb import lzt_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // The run is cut off here. The slowest legal run stays below this limit,
    // even with every reference at the longest length and heavy output stalls.
    localparam int CYCLE_LIMIT  = 200000;
    // Cycles to keep watching after the last expected item, which is longer than one full copy.
    localparam int DRAIN_CYCLES = 40;
    // Input items that reach the parser, not counting padding or bytes after an error.
    localparam int RANDOM_ITEMS = 80;

    // One result item, laid out field by field as the output ports show it.
    typedef struct packed {
        logic [7:0] data;
        logic       vld;
        logic       last;
        logic       done;
        t_status    st;
    } t_result;

    // One directed row. A row with typed set carries its expected result in
    // place of the prediction. Such a row always gives a single result with
    // no byte, so only the done flag and the status are needed.
    typedef struct packed {
        logic [7:0] b;
        logic       sos;
        logic       typed;
        logic       done;
        t_status    st;
    } t_row;

    localparam int N_ROWS = 31;
    localparam t_row DIRECTED_ROWS [N_ROWS] = '{
        // Right after reset the magic is accepted without the start mark.
        // A zero length then finishes the stream as soon as the header ends.
        '{8'h10, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b1, 1'b1, ST_OK},
        // Padding after the end of the stream.
        '{8'hFF, 1'b0, 1'b1, 1'b1, ST_OK},
        // A bad magic latches an error. The next byte is ignored, even if it is a valid magic.
        '{8'hFF, 1'b1, 1'b1, 1'b0, ST_BAD_MAGIC},
        '{8'h10, 1'b0, 1'b1, 1'b0, ST_BAD_MAGIC},
        // Length 20. A literal 0xFF is followed by the longest reference at
        // distance 1, which overlaps its own output. The next reference
        // crosses the declared length and is cut to one byte.
        '{8'h10, 1'b1, 1'b1, 1'b0, ST_OK},
        '{8'h14, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h60, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'hF0, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b0, 1'b0, ST_OK},
        // Length 1, then the largest distance, which exceeds the declared length.
        '{8'h10, 1'b1, 1'b1, 1'b0, ST_OK},
        '{8'h01, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h80, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h0F, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b1, 1'b0, ST_DIST_LEN},
        // Length 4096, then a reference before any byte has been produced.
        '{8'h10, 1'b1, 1'b1, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h10, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h00, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h80, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'h0F, 1'b0, 1'b1, 1'b0, ST_OK},
        '{8'hFF, 1'b0, 1'b1, 1'b0, ST_DIST_PROD}
    };

    // Inputs of the block hold known values from time zero.
    logic       i_clk             = 1'b0;
    logic       i_rst_n           = 1'b0;
    logic       i_valid           = 1'b0;
    logic [7:0] i_in_byte         = 8'h00;
    logic       i_start_of_stream = 1'b0;
    logic       i_stall           = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_last_of_run;
    logic       o_stream_done;
    logic [1:0] o_status;

    // State of the behavioral decoder, with its reset values.
    logic [7:0]  hist_mirror [HIST_DEPTH];
    logic [23:0] produced_cnt = '0;
    logic [23:0] target_len   = '0;
    t_phase      phase        = PH_MAGIC;
    logic [1:0]  hdr_idx      = '0;
    logic [7:0]  flags        = '0;
    logic [3:0]  tok_idx      = '0;
    logic [7:0]  ref_high     = '0;
    t_status     err_st       = ST_OK;

    // Results of the latest input item, and every result still awaited from the block.
    t_result step_out [18];
    int      step_len;
    t_result decoded_q [$];

    // Plan of the random stream generator: the declared length of the
    // current stream, and the distance of the reference being sent.
    logic [23:0] gen_target = '0;
    logic [11:0] gen_dist   = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int err_cnt        = 0;
    int cycle_cnt      = 0;

    lz77_type10_decompressor dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_in_byte         (i_in_byte),
        .i_start_of_stream (i_start_of_stream),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_out_byte        (o_out_byte),
        .o_byte_valid      (o_byte_valid),
        .o_last_of_run     (o_last_of_run),
        .o_stream_done     (o_stream_done),
        .o_status          (o_status)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Watchdog: a hung handshake or a missing result ends up here.
    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("lz77_type10_decompressor test failed");
        $finish;
    end

    // The decoded byte goes into the history and is counted. Done is reported
    // once the count reaches the declared length.
    function automatic void emit_byte(input logic [7:0] v);
        hist_mirror[produced_cnt[HIST_AW-1:0]] = v;
        produced_cnt = produced_cnt + 24'd1;
        step_out[step_len] = '{v, 1'b1, 1'b0, produced_cnt >= target_len, err_st};
        step_len++;
    endfunction

    // Moves to the next token of the group. The stream can end here, or a new flag byte can follow.
    function automatic void next_token();
        flags   = flags << 1;
        tok_idx = tok_idx + 4'd1;
        if (produced_cnt >= target_len) begin
            phase = PH_DONE;
        end else if (tok_idx >= TOKENS_PER_GROUP) begin
            phase = PH_FLAG;
        end else begin
            phase = PH_TOKEN;
        end
    endfunction

    function automatic void latch_error(input t_status code);
        err_st = code;
        phase  = PH_ERROR;
    endfunction

    // Decodes one compressed byte into step_out. Every item gives at least
    // one result, and the last one carries the end-of-run flag.
    function automatic void decode_step(input logic [7:0] b, input logic sos);
        logic [4:0]  run_len;
        logic [12:0] gap;
        int          j;
        step_len = 0;
        if (sos) begin
            phase = PH_MAGIC;
        end
        case (phase)
            PH_MAGIC: begin
                produced_cnt = '0;
                target_len   = '0;
                hdr_idx      = '0;
                flags        = '0;
                tok_idx      = '0;
                ref_high     = '0;
                err_st       = ST_OK;
                if (b != MAGIC_BYTE) begin
                    latch_error(ST_BAD_MAGIC);
                end else begin
                    phase = PH_HEADER;
                end
            end
            PH_HEADER: begin
                // The length arrives little-endian, one byte per item.
                target_len = target_len | (24'(b) << (8 * hdr_idx));
                if (hdr_idx == HDR_LAST_INDEX) begin
                    phase = (target_len == '0) ? PH_DONE : PH_FLAG;
                end
                hdr_idx = hdr_idx + 2'd1;
            end
            PH_FLAG: begin
                flags   = b;
                tok_idx = '0;
                phase   = PH_TOKEN;
            end
            PH_TOKEN: begin
                if (flags[7]) begin
                    ref_high = b;
                    phase    = PH_REFLO;
                end else begin
                    emit_byte(b);
                    next_token();
                end
            end
            PH_REFLO: begin
                run_len = MIN_MATCH + {1'b0, ref_high[7:4]};
                gap     = 13'({ref_high[3:0], b}) + 13'd1;
                // The check against the declared length comes before the check against the bytes produced.
                if (24'(gap) > target_len) begin
                    latch_error(ST_DIST_LEN);
                end else if (24'(gap) > produced_cnt) begin
                    latch_error(ST_DIST_PROD);
                end else begin
                    for (j = 0; j < int'(run_len) && produced_cnt < target_len; j++) begin
                        emit_byte(hist_mirror[HIST_AW'(produced_cnt - 24'(gap))]);
                    end
                    next_token();
                end
            end
            default: begin
            end
        endcase
        if (step_len == 0) begin
            step_out[0] = '{8'h00, 1'b0, 1'b0, phase == PH_DONE, err_st};
            step_len    = 1;
        end
        step_out[step_len-1].last = 1'b1;
    endfunction

    // Offers one item, with random idle cycles before it, and waits for it to
    // be taken. Its expected results are queued at the edge that takes it.
    task automatic send_byte(input logic [7:0] b, input logic sos,
                             input logic typed, input t_result typed_res);
        int k;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_in_byte         <= b;
        i_start_of_stream <= sos;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        decode_step(b, sos);
        if (typed) begin
            decoded_q.push_back(typed_res);
        end else begin
            for (k = 0; k < step_len; k++) begin
                decoded_q.push_back(step_out[k]);
            end
        end
    endtask

    // Chooses the next byte from where the decoder stands now, so most of the
    // traffic forms valid streams. A small share is noise, restarts in the
    // middle of a stream, or references with a random distance that is often
    // out of range.
    task automatic pick_byte(output logic [7:0] b, output logic sos);
        int roll;
        int reach;
        int gap;
        roll = $urandom_range(0, 99);
        sos  = 1'b0;
        b    = 8'($urandom);
        if (roll < 4) begin
            sos = 1'($urandom);
        end else if (roll < 7 || phase == PH_MAGIC || phase == PH_ERROR
                     || (phase == PH_DONE && roll >= 30)) begin
            // Start a new stream. Most lengths are short. A few are zero, and
            // a few are huge, so that every bit of the header bytes is set.
            sos  = 1'b1;
            b    = MAGIC_BYTE;
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                gen_target = '0;
            end else if (roll < 15) begin
                gen_target = 24'($urandom);
            end else begin
                gen_target = 24'($urandom_range(1, 48));
            end
        end else if (phase == PH_HEADER) begin
            b = gen_target[8*hdr_idx +: 8];
        end else if (phase == PH_TOKEN && flags[7]) begin
            reach = (produced_cnt > 24'(HIST_DEPTH)) ? HIST_DEPTH : int'(produced_cnt);
            if (roll < 12 || reach == 0) begin
                gap = $urandom_range(1, HIST_DEPTH);
            end else begin
                gap = $urandom_range(1, reach);
            end
            gen_dist = 12'(gap - 1);
            b        = {4'($urandom), gen_dist[11:8]};
        end else if (phase == PH_REFLO) begin
            b = gen_dist[7:0];
        end
        // A flag byte, a literal, or padding after the end keeps the random value.
    endtask

    // Output side: compares each result item taken with the oldest expectation,
    // then chooses whether to stall in the next cycle.
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_valid && !i_stall) begin
            if (decoded_q.size() == 0) begin
                $error("result item with none expected: out_byte %h byte_valid %b status %0d",
                       o_out_byte, o_byte_valid, o_status);
                err_cnt++;
            end else begin
                exp_res = decoded_q.pop_front();
                if (o_out_byte !== exp_res.data) begin
                    $error("out_byte: expected %h, got %h", exp_res.data, o_out_byte);
                    err_cnt++;
                end
                if (o_byte_valid !== exp_res.vld) begin
                    $error("byte_valid: expected %b, got %b", exp_res.vld, o_byte_valid);
                    err_cnt++;
                end
                if (o_last_of_run !== exp_res.last) begin
                    $error("last_of_run: expected %b, got %b", exp_res.last, o_last_of_run);
                    err_cnt++;
                end
                if (o_stream_done !== exp_res.done) begin
                    $error("stream_done: expected %b, got %b", exp_res.done, o_stream_done);
                    err_cnt++;
                end
                if (o_status !== exp_res.st) begin
                    $error("status: expected %0d, got %0d", exp_res.st, o_status);
                    err_cnt++;
                end
            end
        end
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Stimulus: reset, the directed table with no idling, then random streams
    // in four idling phases, then a drain.
    initial begin
        logic [7:0] rnd_byte;
        logic       rnd_sos;
        int         useful;
        int         quarter;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            send_byte(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].sos, DIRECTED_ROWS[i].typed,
                      '{8'h00, 1'b0, 1'b1, DIRECTED_ROWS[i].done, DIRECTED_ROWS[i].st});
        end

        // Items that the parser ignores (padding and bytes after an error) do not count.
        useful = 0;
        while (useful < RANDOM_ITEMS) begin
            quarter = (useful * 4) / RANDOM_ITEMS;
            case (quarter)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 58;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 58;
                end
                default: begin
                    send_idle_pct  = 17;
                    recv_stall_pct = 17;
                end
            endcase
            pick_byte(rnd_byte, rnd_sos);
            if (rnd_sos || (phase != PH_DONE && phase != PH_ERROR)) begin
                useful++;
            end
            send_byte(rnd_byte, rnd_sos, 1'b0, '0);
        end
        i_valid <= 1'b0;

        // Any leftover expectation keeps this loop waiting until the watchdog fires.
        while (decoded_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("lz77_type10_decompressor test passed");
        end else begin
            $display("lz77_type10_decompressor test failed");
        end
        $finish;
    end

endmodule
